@@ rtl/epd_pkg.sv @@
// Shared types, character codes and helpers for the escaped path decoder.
`default_nettype none
package epd_pkg;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // character codes
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_SEVEN  = 8'h37;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_V      = 8'h76;
   localparam logic [7:0] CH_NUL    = 8'h00;

   localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_ESC   = 2'd1,
      MODE_OCT   = 2'd2
   } mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_end;
   } result_type;

   // one queue entry: the one or two results caused by one input word
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } qstat_type;

   typedef struct packed {
      logic       emit;
      result_type res;
      logic       to_esc;
   } plain_type;

   function automatic logic is_white(input logic [7:0] c);
      is_white = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
                 (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
   endfunction

   function automatic logic is_octal(input logic [7:0] c);
      is_octal = (c >= CH_ZERO) && (c <= CH_SEVEN);
   endfunction

   // handling of a character outside any escape
   function automatic plain_type plain_char(input logic [7:0] c, input logic at_end);
      plain_type p;
      p.emit         = 1'b0;
      p.res.out_byte = CH_NUL;
      p.res.is_end   = 1'b0;
      p.to_esc       = 1'b0;
      if (at_end || is_white(c)) begin
         p.emit       = 1'b1;
         p.res.is_end = 1'b1;
      end else if (c == CH_BSLASH) begin
         p.to_esc = 1'b1;
      end else begin
         p.emit         = 1'b1;
         p.res.out_byte = c;
      end
      plain_char = p;
   endfunction

endpackage
`default_nettype wire

@@ rtl/epd_front.sv @@
// Front: accepts input words, tracks escape state, builds queue entries.
`default_nettype none
module epd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         in_byte,
   input  wire logic               at_end,
   output logic                    push,
   output epd_pkg::entry_type      entry
);

   epd_pkg::mode_type mode_ff, mode_in;
   logic [8:0]        oval_ff, oval_in;
   logic [1:0]        odig_ff, odig_in;

   logic [2:0]        digit;
   logic              oct_c;
   logic [8:0]        oval_next;
   logic [1:0]        odig_next;
   logic              oct_take;
   epd_pkg::plain_type pc;

   assign digit     = in_byte[2:0];
   assign oct_c     = epd_pkg::is_octal(in_byte);
   assign oval_next = {oval_ff[5:0], 3'b000} + {6'b0, digit};
   assign odig_next = odig_ff + 2'd1;
   assign oct_take  = !at_end && oct_c && (odig_ff < epd_pkg::OCT_MAX_DIGITS);
   assign pc        = epd_pkg::plain_char(in_byte, at_end);

   // next state
   always_comb begin
      mode_in = mode_ff;
      oval_in = oval_ff;
      odig_in = odig_ff;
      unique case (mode_ff)
         epd_pkg::MODE_ESC: begin
            mode_in = epd_pkg::MODE_PLAIN;
            if (!at_end && oct_c &&
                !(in_byte == epd_pkg::CH_BSLASH || in_byte == epd_pkg::CH_SPACE)) begin
               mode_in = epd_pkg::MODE_OCT;
               oval_in = {6'b0, digit};
               odig_in = 2'd1;
            end
         end
         epd_pkg::MODE_OCT: begin
            if (oct_take && odig_next < epd_pkg::OCT_MAX_DIGITS) begin
               oval_in = oval_next;
               odig_in = odig_next;
            end else begin
               oval_in = 9'd0;
               odig_in = 2'd0;
               mode_in = (!oct_take && pc.to_esc) ? epd_pkg::MODE_ESC
                                                  : epd_pkg::MODE_PLAIN;
            end
         end
         default: begin
            mode_in = pc.to_esc ? epd_pkg::MODE_ESC : epd_pkg::MODE_PLAIN;
         end
      endcase
   end

   // results
   always_comb begin
      push              = 1'b0;
      entry.two         = 1'b0;
      entry.r0.out_byte = epd_pkg::CH_NUL;
      entry.r0.is_end   = 1'b0;
      entry.r1.out_byte = epd_pkg::CH_NUL;
      entry.r1.is_end   = 1'b0;
      unique case (mode_ff)
         epd_pkg::MODE_ESC: begin
            push = 1'b1;
            if (at_end) begin
               entry.two = 1'b1;
               entry.r1  = pc.res;
            end else if (in_byte == epd_pkg::CH_BSLASH || in_byte == epd_pkg::CH_SPACE) begin
               entry.r0.out_byte = in_byte;
            end else if (in_byte == epd_pkg::CH_N) begin
               entry.r0.out_byte = epd_pkg::CH_LF;
            end else if (in_byte == epd_pkg::CH_R) begin
               entry.r0.out_byte = epd_pkg::CH_CR;
            end else if (in_byte == epd_pkg::CH_T) begin
               entry.r0.out_byte = epd_pkg::CH_TAB;
            end else if (in_byte == epd_pkg::CH_B) begin
               entry.r0.out_byte = epd_pkg::CH_BS;
            end else if (in_byte == epd_pkg::CH_F) begin
               entry.r0.out_byte = epd_pkg::CH_FF;
            end else if (in_byte == epd_pkg::CH_V) begin
               entry.r0.out_byte = epd_pkg::CH_VT;
            end else if (oct_c) begin
               push = 1'b0;
            end else begin
               // unknown escape: zero byte, then the char as plain text
               entry.two = pc.emit;
               entry.r1  = pc.res;
            end
         end
         epd_pkg::MODE_OCT: begin
            if (oct_take) begin
               push              = (odig_next >= epd_pkg::OCT_MAX_DIGITS);
               entry.r0.out_byte = oval_next[7:0];
            end else begin
               push              = 1'b1;
               entry.r0.out_byte = oval_ff[7:0];
               entry.two         = pc.emit;
               entry.r1          = pc.res;
            end
         end
         default: begin
            push     = pc.emit;
            entry.r0 = pc.res;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= epd_pkg::MODE_PLAIN;
         oval_ff <= 9'd0;
         odig_ff <= 2'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         oval_ff <= oval_in;
         odig_ff <= odig_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/epd_queue.sv @@
// Short entry queue between the decode front and the output back.
`default_nettype none
module epd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire epd_pkg::entry_type wr_entry,
   input  wire logic               pop,
   output epd_pkg::entry_type      head,
   output epd_pkg::qstat_type      stat
);

   epd_pkg::entry_type                mem_ff [epd_pkg::QUEUE_DEPTH];
   logic [epd_pkg::QPTR_W-1:0]        wptr_ff, wptr_in;
   logic [epd_pkg::QPTR_W-1:0]        rptr_ff, rptr_in;
   logic [epd_pkg::QCNT_W-1:0]        cnt_ff, cnt_in;

   assign stat.not_empty = (cnt_ff != '0);
   assign stat.full      = (cnt_ff == epd_pkg::QCNT_W'(epd_pkg::QUEUE_DEPTH));
   assign head           = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = pop  ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/epd_back.sv @@
// Back: walks the results of the head entry out onto the result channel.
`default_nettype none
module epd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire epd_pkg::entry_type head,
   input  wire epd_pkg::qstat_type stat,
   input  wire logic               out_ready,
   output logic                    out_valid,
   output epd_pkg::result_type     out_res,
   output logic                    out_last,
   output logic                    pop
);

   logic sel_ff, sel_in;
   logic fire;

   assign out_valid = stat.not_empty;
   assign out_res   = sel_ff ? head.r1 : head.r0;
   assign out_last  = sel_ff || !head.two;
   assign fire      = out_valid && out_ready;
   assign pop       = fire && out_last;

   always_comb begin
      sel_in = sel_ff;
      if (fire) begin
         sel_in = !out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/escaped_path_decoder.sv @@
// Top level of the escaped path decoder.
//
// Input channel req_*: one word per raw character of backslash-escaped
// text, or an end-of-input mark (req_tuser high, req_tdata ignored).
// Result channel rsp_*: decoded path bytes; rsp_tuser high marks the end
// of a path (data zero then), rsp_tlast marks the final result of the
// input word that caused it. One input word gives zero, one or two results.
//
// A result is registered in the queue when its input word is taken and
// is offered on rsp_* from the queue head. Throughput: one input word per
// cycle; a word that gives two results holds the result side for both,
// the front keeps taking words until the four-entry queue between decode
// and output fills. Words giving no result (backslash, leading octal
// digits) reach no queue entry.
//
// Reset (synchronous, active high) returns the escape state to plain text
// and empties the queue. When the receiver stalls, the head result holds
// and req_tready falls once the queue is full.
`default_nettype none
module escaped_path_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tuser,   // [0] at_end
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tuser,   // [0] is_end
   output logic            rsp_tlast
);

   epd_pkg::entry_type  fe_entry;
   epd_pkg::entry_type  q_head;
   epd_pkg::qstat_type  q_stat;
   epd_pkg::result_type be_res;
   logic                fe_push;
   logic                req_accept;
   logic                be_pop;

   // front only stalls on a full queue
   assign req_tready = !q_stat.full;
   assign req_accept = req_tvalid && req_tready;

   epd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .in_byte (req_tdata),
      .at_end  (req_tuser),
      .push    (fe_push),
      .entry   (fe_entry)
   );

   epd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fe_push && req_accept),
      .wr_entry (fe_entry),
      .pop      (be_pop),
      .head     (q_head),
      .stat     (q_stat)
   );

   epd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .stat      (q_stat),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_res   (be_res),
      .out_last  (rsp_tlast),
      .pop       (be_pop)
   );

   assign rsp_tdata = be_res.out_byte;
   assign rsp_tuser = be_res.is_end;

endmodule
`default_nettype wire

@@ rtl/epd_checker.sv @@
// Port-level checks for the escaped path decoder, bound to the top level.
`default_nettype none
module epd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tuser
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // end marker carries no byte
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'h00)
      else $error("end marker with nonzero data");

   // reset leaves nothing queued
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result offered right after reset");

   // a stalled front means the queue holds results
   a_stall_backed: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req_tready low with no result pending");

endmodule

bind escaped_path_decoder epd_checker u_epd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

@@ tb/escaped_path_decoder_tb.sv @@
// Self-checking testbench for the escaped path decoder: directed, random and backpressure traffic.
module escaped_path_decoder_tb;

   // one decoded result as seen on rsp_*
   typedef struct packed {
      logic [7:0] data;
      logic       path_end;
      logic       word_last;
   } path_result_type;

   // separators and the single-letter escapes, for picking at random
   localparam logic [7:0] SEPARATORS [6] = '{epd_pkg::CH_SPACE, epd_pkg::CH_TAB,
      epd_pkg::CH_LF, epd_pkg::CH_VT, epd_pkg::CH_FF, epd_pkg::CH_CR};
   localparam logic [7:0] ESC_LETTERS [8] =
      '{epd_pkg::CH_N, epd_pkg::CH_R, epd_pkg::CH_T, epd_pkg::CH_B, epd_pkg::CH_F,
        epd_pkg::CH_V, epd_pkg::CH_BSLASH, epd_pkg::CH_SPACE};

   // longest wait for the whole run: far beyond the slowest legal run
   localparam int RUN_LIMIT_CYCLES = 200000;
   // cycles let pass after the last result
   localparam int TAIL_CYCLES      = 4;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] in_byte
   logic       req_tuser;    // [0] at_end
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [7:0] out_byte
   logic       rsp_tuser;    // [0] is_end
   logic       rsp_tlast;

   // decoder state mirrored by the predictor
   epd_pkg::mode_type dec_mode;
   logic [8:0]        oct_acc;
   logic [1:0]        oct_count;

   // results of the word being predicted, then the store of pending ones
   path_result_type step_out [2];
   int              step_count;
   path_result_type expected_results [$];

   int  send_idle_pct;
   int  rsp_idle_pct;
   int  rsp_hold_cycles;
   int  words_sent;
   bit  mismatch_seen;

   escaped_path_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   task automatic add_result(input logic [7:0] b, input logic path_end);
      step_out[step_count].data      = path_end ? epd_pkg::CH_NUL : b;
      step_out[step_count].path_end  = path_end;
      step_out[step_count].word_last = 1'b0;
      step_count++;
   endtask

   function automatic logic is_separator(input logic [7:0] c);
      is_separator = (c == epd_pkg::CH_SPACE) || (c == epd_pkg::CH_TAB) ||
                     (c == epd_pkg::CH_LF) || (c == epd_pkg::CH_VT) ||
                     (c == epd_pkg::CH_FF) || (c == epd_pkg::CH_CR);
   endfunction

   function automatic logic is_oct_digit(input logic [7:0] c);
      is_oct_digit = (c >= epd_pkg::CH_ZERO) && (c <= epd_pkg::CH_SEVEN);
   endfunction

   // character outside an escape: separator/end closes the path,
   // backslash opens an escape, anything else is a path byte
   task automatic decode_unescaped(input logic [7:0] c, input logic at_end);
      if (at_end || is_separator(c)) begin
         add_result(epd_pkg::CH_NUL, 1'b1);
      end else if (c == epd_pkg::CH_BSLASH) begin
         dec_mode = epd_pkg::MODE_ESC;
      end else begin
         add_result(c, 1'b0);
      end
   endtask

   task automatic predict_word(input logic [7:0] c, input logic at_end);
      logic [7:0] digit;
      digit      = c - epd_pkg::CH_ZERO;
      step_count = 0;
      if (dec_mode == epd_pkg::MODE_ESC) begin
         dec_mode = epd_pkg::MODE_PLAIN;
         if (at_end) begin
            // dangling backslash: zero byte, then the path closes
            add_result(epd_pkg::CH_NUL, 1'b0);
            decode_unescaped(c, at_end);
         end else begin
            case (c)
               epd_pkg::CH_BSLASH, epd_pkg::CH_SPACE: add_result(c, 1'b0);
               epd_pkg::CH_N: add_result(epd_pkg::CH_LF, 1'b0);
               epd_pkg::CH_R: add_result(epd_pkg::CH_CR, 1'b0);
               epd_pkg::CH_T: add_result(epd_pkg::CH_TAB, 1'b0);
               epd_pkg::CH_B: add_result(epd_pkg::CH_BS, 1'b0);
               epd_pkg::CH_F: add_result(epd_pkg::CH_FF, 1'b0);
               epd_pkg::CH_V: add_result(epd_pkg::CH_VT, 1'b0);
               default: begin
                  if (is_oct_digit(c)) begin
                     dec_mode  = epd_pkg::MODE_OCT;
                     oct_acc   = {6'd0, digit[2:0]};
                     oct_count = 2'd1;
                  end else begin
                     // unknown escape: zero byte, char handled again as plain
                     add_result(epd_pkg::CH_NUL, 1'b0);
                     decode_unescaped(c, at_end);
                  end
               end
            endcase
         end
      end else if (dec_mode == epd_pkg::MODE_OCT) begin
         if (!at_end && is_oct_digit(c) && oct_count < epd_pkg::OCT_MAX_DIGITS) begin
            oct_acc   = (oct_acc << 3) + {6'd0, digit[2:0]};
            oct_count = oct_count + 2'd1;
            // third digit closes the escape at once, value taken mod 256
            if (oct_count == epd_pkg::OCT_MAX_DIGITS) begin
               add_result(oct_acc[7:0], 1'b0);
               dec_mode  = epd_pkg::MODE_PLAIN;
               oct_acc   = '0;
               oct_count = '0;
            end
         end else begin
            // run cut short: flush the value, then the word counts afresh
            add_result(oct_acc[7:0], 1'b0);
            dec_mode  = epd_pkg::MODE_PLAIN;
            oct_acc   = '0;
            oct_count = '0;
            decode_unescaped(c, at_end);
         end
      end else begin
         dec_mode = epd_pkg::MODE_PLAIN;
         decode_unescaped(c, at_end);
      end
      if (step_count > 0) step_out[step_count - 1].word_last = 1'b1;
      for (int i = 0; i < step_count; i++) expected_results.push_back(step_out[i]);
   endtask

   // ------------------------------------------------------------------
   // Input side: drives at the falling edge, accepts at the rising edge
   // ------------------------------------------------------------------

   task automatic send_word(input logic [7:0] b, input logic at_end);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tuser  = at_end;
      do @(posedge clock); while (!req_tready);
      predict_word(b, at_end);
      words_sent++;
   endtask

   task automatic send_char(input logic [7:0] b);
      send_word(b, 1'b0);
   endtask

   // end mark carries a random, ignored byte
   task automatic send_end_mark();
      send_word(8'($urandom), 1'b1);
   endtask

   // sender stops and waits until every pending result has been seen
   task automatic wait_results_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Result side: random stalls, plus a long hold-off on request
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready      = 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else begin
         rsp_tready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // every accepted result is matched against the oldest expectation
   always @(posedge clock) begin
      path_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result data %02h end %0b last %0b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_seen = 1'b1;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata !== want.data) begin
               $display("%0t: out_byte expected %02h actual %02h",
                        $time, want.data, rsp_tdata);
               mismatch_seen = 1'b1;
            end
            if (rsp_tuser !== want.path_end) begin
               $display("%0t: is_end expected %0b actual %0b",
                        $time, want.path_end, rsp_tuser);
               mismatch_seen = 1'b1;
            end
            if (rsp_tlast !== want.word_last) begin
               $display("%0t: last expected %0b actual %0b",
                        $time, want.word_last, rsp_tlast);
               mismatch_seen = 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // extremes of the byte, every escape letter and the escape corner cases
   task automatic test_directed();
      send_char(8'h00);
      send_char(8'hFF);
      foreach (ESC_LETTERS[i]) begin
         send_char(epd_pkg::CH_BSLASH);
         send_char(ESC_LETTERS[i]);
      end
      // three digits: 0777 wraps to ff
      send_char(epd_pkg::CH_BSLASH);
      send_char(epd_pkg::CH_SEVEN);
      send_char(epd_pkg::CH_SEVEN);
      send_char(epd_pkg::CH_SEVEN);
      // one digit cut short by a plain char
      send_char(epd_pkg::CH_BSLASH); send_char(8'h35); send_char(8'h78);
      // two digits cut short by end of input
      send_char(epd_pkg::CH_BSLASH); send_char(8'h31); send_char(8'h32); send_end_mark();
      // backslash then end of input
      send_char(epd_pkg::CH_BSLASH); send_end_mark();
      // unknown escape
      send_char(epd_pkg::CH_BSLASH); send_char(8'h7A);
      // a separator then end of input: the second closes an empty path
      send_char(epd_pkg::CH_TAB); send_end_mark();
   endtask

   // mostly well-formed escaped text, some noise and broken escapes
   task automatic test_random_text(input int n_words);
      int target;
      int pick;
      int n_digits;
      target = words_sent + n_words;
      while (words_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            send_char(8'($urandom_range(8'h21, 8'h7E)));
         end else if (pick < 42) begin
            send_char(SEPARATORS[$urandom_range(5)]);
         end else if (pick < 47) begin
            send_end_mark();
         end else if (pick < 62) begin
            send_char(epd_pkg::CH_BSLASH);
            send_char(ESC_LETTERS[$urandom_range(7)]);
         end else if (pick < 80) begin
            // octal run, length 1..3; what follows may cut it short
            send_char(epd_pkg::CH_BSLASH);
            n_digits = $urandom_range(1, 3);
            repeat (n_digits) send_char(epd_pkg::CH_ZERO + 8'($urandom_range(7)));
         end else if (pick < 88) begin
            send_char(epd_pkg::CH_BSLASH);
            if ($urandom_range(7) == 0) send_end_mark();
            else send_char(8'($urandom));
         end else begin
            send_char(8'($urandom));
         end
      end
   endtask

   // receiver holds off while words keep coming, so the queue fills
   // and req_tready drops; then the sender waits for the drain
   task automatic test_backpressure();
      send_idle_pct   = 0;
      rsp_idle_pct    = 0;
      rsp_hold_cycles = 80;
      repeat (24) send_char(8'($urandom_range(8'h41, 8'h5A)));
      wait_results_drained();
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = 1'b0;
      rsp_tready      = 1'b0;
      rsp_hold_cycles = 0;
      send_idle_pct   = 0;
      rsp_idle_pct    = 0;
      words_sent      = 0;
      mismatch_seen   = 1'b0;
      dec_mode        = epd_pkg::MODE_PLAIN;
      oct_acc         = '0;
      oct_count       = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // sender rarely idles, receiver mostly stalls
      send_idle_pct = 7;
      rsp_idle_pct  = 65;
      test_directed();
      test_random_text(115);
      wait_results_drained();

      // sender mostly idles, receiver rarely stalls
      send_idle_pct = 65;
      rsp_idle_pct  = 7;
      test_random_text(115);
      wait_results_drained();

      test_backpressure();

      // full rate both ways
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random_text(115);
      wait_results_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (!mismatch_seen && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // hung handshake or missing results
   initial begin
      #(20 * RUN_LIMIT_CYCLES);
      $display("== FAIL ==");
      $finish;
   end

endmodule
